// ----- rtl/core/stffa_pkg.sv -----
// Shared types and constants of the sorted-table first-fit allocator.
// Used by the arithmetic unit, the table memory, the sequencer and the top level.
// Depends on nothing else.
package stffa_pkg;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 20;
  localparam int NEED_W  = LEN_W + 1;
  localparam int END_W   = ADDR_W + 1;
  localparam int SUM_W   = ADDR_W + 2;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] ALIGN_MASK = 32'hFFFF_FFFC;
  localparam logic [ADDR_W-1:0] WIN_BASE_RST  = 32'h2000_0000;
  localparam logic [ADDR_W-1:0] WIN_LIMIT_RST = 32'h2000_5000;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_ORDER    = 3'd5;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LIMIT = 2'd1;

  // One live block of the table.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // Operands of the shared arithmetic unit.
  typedef struct packed {
    logic [END_W-1:0]  a;
    logic [NEED_W-1:0] b;
    logic [ADDR_W-1:0] c;
  } alu_in_t;

  // Results of the shared arithmetic unit.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             sum_lt_c;
    logic             a_gt_c;
    logic             a_eq_c;
  } alu_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_BASE,
    S_A_CMP,
    S_A_END,
    S_A_TAIL,
    S_A_ALIGN,
    S_S_MV,
    S_INS,
    S_R_CMP,
    S_D_MV,
    S_D_FIN,
    S_FIN
  } state_t;

endpackage

// ----- rtl/core/stffa_alu.sv -----
// Shared add and compare unit of the allocator sequencer.
// Depends on stffa_pkg for its operand and result structs.
module stffa_alu (
  input  stffa_pkg::alu_in_t  alu_in,
  output stffa_pkg::alu_out_t alu_out
);
  import stffa_pkg::*;

  // The sum is wide enough that no address sum wraps.
  assign alu_out.sum      = SUM_W'(alu_in.a) + SUM_W'(alu_in.b);
  assign alu_out.sum_lt_c = alu_out.sum < SUM_W'(alu_in.c);
  assign alu_out.a_gt_c   = alu_in.a > END_W'(alu_in.c);
  assign alu_out.a_eq_c   = alu_in.a == END_W'(alu_in.c);

endmodule

// ----- rtl/core/stffa_mem.sv -----
// Block table storage: one write port and one registered read port.
// Depends on stffa_pkg for the entry type.
module stffa_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  stffa_pkg::entry_t        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output stffa_pkg::entry_t        rd_data
);
  import stffa_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/stffa_ctrl.sv -----
// Sequencer of the allocator: scans, shifts and inserts table entries.
// Depends on stffa_pkg, stffa_alu and stffa_mem.
module stffa_ctrl #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              req_opcode,
  input  logic [stffa_pkg::LEN_W-1:0]       req_size,
  input  logic [stffa_pkg::ADDR_W-1:0]      req_free_address,
  input  logic [stffa_pkg::ADDR_W-1:0]      win_base,
  input  logic [stffa_pkg::ADDR_W-1:0]      win_limit,
  output logic                              res_valid,
  input  logic                              res_take,
  output logic [stffa_pkg::ADDR_W-1:0]      res_address,
  output logic [stffa_pkg::STAT_W-1:0]      res_status,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]   block_count
);
  import stffa_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);
  localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);

  state_t state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [END_W-1:0]  end_r, end_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]  size_r, size_nxt;
  logic [ADDR_W-1:0] faddr_r, faddr_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  alu_in_t  alu_in;
  alu_out_t alu_out;

  logic          wr_en, rd_en;
  logic [CW-1:0] wr_idx, rd_idx;
  entry_t        wr_data, rd_data;

  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] need_m1;
  logic              req_fire;
  logic              last_idx;

  assign req_ready = state_r == S_IDLE;
  assign req_fire  = req_valid && req_ready;
  assign need      = NEED_W'(size_r) + NEED_W'(4);
  assign need_m1   = NEED_W'(size_r) + NEED_W'(3);
  assign last_idx  = (idx_r + ONE) == count_r;

  assign res_valid   = state_r == S_FIN;
  assign res_address = addr_r;
  assign res_status  = status_r;
  assign block_count = count_r;

  stffa_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  stffa_mem #(
    .DEPTH (MAX_BLOCKS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[IW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[IW-1:0]),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_fire) begin
          if (req_opcode == OP_RELEASE) begin
            state_nxt = (count_r == '0) ? S_FIN : S_R_CMP;
          end else if (req_size == '0 || count_r == FULL) begin
            state_nxt = S_FIN;
          end else if (count_r == '0) begin
            state_nxt = S_A_BASE;
          end else begin
            state_nxt = S_A_END;
          end
        end
      end
      S_A_BASE:  state_nxt = alu_out.sum_lt_c ? S_A_ALIGN : S_FIN;
      S_A_CMP: begin
        if (alu_out.a_gt_c) begin
          state_nxt = S_FIN;
        end else if (alu_out.sum_lt_c) begin
          state_nxt = S_A_ALIGN;
        end else begin
          state_nxt = S_A_END;
        end
      end
      S_A_END:   state_nxt = last_idx ? S_A_TAIL : S_A_CMP;
      S_A_TAIL:  state_nxt = alu_out.sum_lt_c ? S_A_ALIGN : S_FIN;
      S_A_ALIGN: state_nxt = (count_r == pos_r) ? S_INS : S_S_MV;
      S_S_MV:    state_nxt = ((idx_r - ONE) == pos_r) ? S_INS : S_S_MV;
      S_INS:     state_nxt = S_FIN;
      S_R_CMP: begin
        if (alu_out.a_eq_c) begin
          state_nxt = last_idx ? S_D_FIN : S_D_MV;
        end else if (last_idx) begin
          state_nxt = S_FIN;
        end
      end
      S_D_MV:    state_nxt = ((idx_r + TWO) == count_r) ? S_D_FIN : S_D_MV;
      S_D_FIN:   state_nxt = S_FIN;
      S_FIN:     state_nxt = res_take ? S_IDLE : S_FIN;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls and register updates.
  always_comb begin
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    end_nxt    = end_r;
    addr_nxt   = addr_r;
    size_nxt   = size_r;
    faddr_nxt  = faddr_r;
    status_nxt = status_r;
    alu_in     = '0;
    wr_en      = 1'b0;
    wr_idx     = idx_r;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_idx     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (req_fire) begin
          size_nxt   = req_size;
          faddr_nxt  = req_free_address;
          addr_nxt   = '0;
          idx_nxt    = '0;
          status_nxt = ST_OK;
          rd_en      = 1'b1;
          if (req_opcode == OP_RELEASE) begin
            if (count_r == '0) begin
              status_nxt = ST_NOTFOUND;
            end
          end else if (req_size == '0) begin
            status_nxt = ST_ZERO;
          end else if (count_r == FULL) begin
            status_nxt = ST_FULL;
          end
        end
      end
      S_A_BASE: begin
        alu_in.a = END_W'(win_base);
        alu_in.b = need;
        alu_in.c = win_limit;
        end_nxt  = END_W'(win_base);
        pos_nxt  = '0;
        if (!alu_out.sum_lt_c) begin
          status_nxt = ST_NOSPACE;
        end
      end
      S_A_CMP: begin
        // Gap test: previous end plus the request plus three lies below the next
        // start, which is the same as the gap holding the request plus four.
        alu_in.a = end_r;
        alu_in.b = need_m1;
        alu_in.c = rd_data.start;
        pos_nxt  = idx_r;
        if (alu_out.a_gt_c) begin
          status_nxt = ST_ORDER;
        end
      end
      S_A_END: begin
        alu_in.a = END_W'(rd_data.start);
        alu_in.b = NEED_W'(rd_data.len);
        end_nxt  = alu_out.sum[END_W-1:0];
        if (!last_idx) begin
          idx_nxt = idx_r + ONE;
          rd_en   = 1'b1;
          rd_idx  = idx_r + ONE;
        end
      end
      S_A_TAIL: begin
        alu_in.a = end_r;
        alu_in.b = need;
        alu_in.c = win_limit;
        pos_nxt  = count_r;
        if (!alu_out.sum_lt_c) begin
          status_nxt = ST_NOSPACE;
        end
      end
      S_A_ALIGN: begin
        alu_in.a = end_r;
        alu_in.b = NEED_W'(3);
        addr_nxt = alu_out.sum[ADDR_W-1:0] & ALIGN_MASK;
        idx_nxt  = count_r;
        rd_en    = 1'b1;
        rd_idx   = count_r - ONE;
      end
      S_S_MV: begin
        // Move entry idx-1 up to idx while fetching the one below it.
        wr_en   = 1'b1;
        wr_idx  = idx_r;
        idx_nxt = idx_r - ONE;
        rd_en   = 1'b1;
        rd_idx  = idx_r - TWO;
      end
      S_INS: begin
        wr_en         = 1'b1;
        wr_idx        = pos_r;
        wr_data.start = addr_r;
        wr_data.len   = size_r;
        count_nxt     = count_r + ONE;
      end
      S_R_CMP: begin
        alu_in.a = END_W'(rd_data.start);
        alu_in.c = faddr_r;
        if (alu_out.a_eq_c || !last_idx) begin
          rd_en  = 1'b1;
          rd_idx = idx_r + ONE;
        end
        if (!alu_out.a_eq_c) begin
          if (last_idx) begin
            status_nxt = ST_NOTFOUND;
          end else begin
            idx_nxt = idx_r + ONE;
          end
        end
      end
      S_D_MV: begin
        // Move entry idx+1 down to idx while fetching the next one.
        wr_en   = 1'b1;
        wr_idx  = idx_r;
        idx_nxt = idx_r + ONE;
        rd_en   = 1'b1;
        rd_idx  = idx_r + TWO;
      end
      S_D_FIN: begin
        count_nxt = count_r - ONE;
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    end_r    <= end_nxt;
    addr_r   <= addr_nxt;
    size_r   <= size_nxt;
    faddr_r  <= faddr_nxt;
    status_r <= status_nxt;
  end

endmodule

// ----- rtl/core/sorted_table_first_fit_allocator_top.sv -----
// Top level of the sorted-table first-fit heap allocator.
// Holds the heap window registers and the result register; depends on stffa_pkg
// and stffa_ctrl.
//
// Usage. Requests arrive on the in_ channel (valid/ready): an allocate carries a
// byte count, a release carries the start address of a live block. Each request
// yields exactly one transfer on the out_ channel with the block address, a
// success flag and a status code. The cfg_ channel writes the window base (index 0)
// or the window limit (index 1); it is always ready and should only be used while
// the block is idle. Other indices are ignored.
//
// Operation. One request is handled at a time and in_ready is low while it runs.
// A zero-size allocate, an allocate on a full table and a release on an empty
// table go straight to the result. Otherwise an allocate walks the table in
// address order, testing the gap after each entry and then the gap at the tail,
// and when a gap fits moves any later entries up and inserts the new one; a
// release searches for the address and, when it is found, moves the later entries
// down. The single table read port and the one shared adder set the pace of this
// work.
//
// Reset clears the table fill count, so the table is empty, and loads the
// default heap window. When the receiver stalls the result waits in the output
// register; the next request is still taken, and its own result is held back
// until the register has been emptied.
module sorted_table_first_fit_allocator_top #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [stffa_pkg::LEN_W-1:0]         in_alloc_size,
  input  logic [stffa_pkg::ADDR_W-1:0]        in_free_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stffa_pkg::ADDR_W-1:0]        out_block_address,
  output logic                                out_success,
  output logic [stffa_pkg::STAT_W-1:0]        out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stffa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stffa_pkg::ADDR_W-1:0]        cfg_data
);
  import stffa_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic [ADDR_W-1:0] win_base_r, win_base_nxt;
  logic [ADDR_W-1:0] win_limit_r, win_limit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [STAT_W-1:0] out_status_r;

  logic              res_valid, res_take;
  logic [ADDR_W-1:0] res_address;
  logic [STAT_W-1:0] res_status;
  logic [CW-1:0]     block_count;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indices leave both registers untouched.
  always_comb begin
    win_base_nxt  = win_base_r;
    win_limit_nxt = win_limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIN_BASE:  win_base_nxt  = cfg_data;
        CFG_WIN_LIMIT: win_limit_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  stffa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (in_valid),
    .req_ready        (in_ready),
    .req_opcode       (in_opcode),
    .req_size         (in_alloc_size),
    .req_free_address (in_free_address),
    .win_base         (win_base_r),
    .win_limit        (win_limit_r),
    .res_valid        (res_valid),
    .res_take         (res_take),
    .res_address      (res_address),
    .res_status       (res_status),
    .block_count      (block_count)
  );

  // The finished result moves into the output register once that is free.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_base_r  <= WIN_BASE_RST;
      win_limit_r <= WIN_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      win_base_r  <= win_base_nxt;
      win_limit_r <= win_limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_addr_r   <= res_address;
      out_status_r <= res_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_success       = out_status_r == ST_OK;

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    block_count <= CW'(MAX_BLOCKS))
    else $error("block table fill count beyond its depth");

  // A returned non-zero address is word aligned and belongs to a success.
  a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_block_address != '0) |-> (out_block_address[1:0] == 2'b00) && out_success)
    else $error("returned block address is unaligned or carries a failure");

  // Once a request is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a previous one is still running");

  // A result handed over is visible on the output in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid)
    else $error("finished result did not reach the output register");

endmodule
